/* hw/rtl/tsfp_pkg.sv */
`default_nettype none

package tsfp_pkg;

    // Result kinds
    localparam logic [1:0] KIND_FIELD   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    // Message types, in header priority order
    localparam logic [1:0] MSG_GPS = 2'd0;
    localparam logic [1:0] MSG_IMU = 2'd1;
    localparam logic [1:0] MSG_VIS = 2'd2;
    localparam logic [1:0] MSG_CMD = 2'd3;

    localparam int unsigned HDR_LEN = 4;

    // Result queue
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Characters
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

    typedef enum logic [1:0] {
        PH_SPACE  = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         msg_type;
        logic [4:0]         field_index;
        logic signed [31:0] value;
        logic               last;
    } t_result;

    // Up to two results from one byte; res0 goes out first
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_emit;

    // Header text "$GPS", "$IMU", "$VIS", "$CMD"
    function automatic logic [7:0] hdr_char(input logic [1:0] t, input logic [1:0] p);
        logic [7:0] c;
        unique case ({t, p})
            {MSG_GPS, 2'd1}: c = 8'h47;
            {MSG_GPS, 2'd2}: c = 8'h50;
            {MSG_GPS, 2'd3}: c = 8'h53;
            {MSG_IMU, 2'd1}: c = 8'h49;
            {MSG_IMU, 2'd2}: c = 8'h4D;
            {MSG_IMU, 2'd3}: c = 8'h55;
            {MSG_VIS, 2'd1}: c = 8'h56;
            {MSG_VIS, 2'd2}: c = 8'h49;
            {MSG_VIS, 2'd3}: c = 8'h53;
            {MSG_CMD, 2'd1}: c = 8'h43;
            {MSG_CMD, 2'd2}: c = 8'h4D;
            {MSG_CMD, 2'd3}: c = 8'h44;
            default:         c = CH_DOLLAR;
        endcase
        return c;
    endfunction

    // Number of numeric fields emitted per type (command type handled apart)
    function automatic logic [3:0] field_limit(input logic [1:0] t);
        logic [3:0] lim;
        unique case (t)
            MSG_GPS: lim = 4'd7;
            MSG_IMU: lim = 4'd9;
            MSG_VIS: lim = 4'd6;
            MSG_CMD: lim = 4'd0;
        endcase
        return lim;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/telemetry_sentence_field_parser_unit.sv */
// Path: each byte is held in the input register, parsed combinationally, and its
//   results are written into the result queue, whose head drives the output ports.
// Throughput: one byte per cycle while the result queue has room for two results; a byte
//   that closes a line with an open field gives two results, which leave in order through a 4-entry result queue.
// Reset: i_rst_n synchronous, active low; clears the line state, the input stage and
//   the queue count. No clearing pass is needed.
`default_nettype none

module telemetry_sentence_field_parser_unit #(
    parameter int unsigned LINE_STORE_BYTES = 256,
    parameter int unsigned PAYLOAD_MAX      = 31
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // byte input channel
    input  wire logic               i_rx_valid,
    output logic                    o_rx_ready,
    input  wire logic [7:0]         i_rx_byte,
    // result channel
    output logic                    o_res_valid,
    input  wire logic               i_res_ready,
    output logic [1:0]              o_kind,
    output logic [1:0]              o_msg_type,
    output logic [4:0]              o_field_index,
    output logic signed [31:0]      o_value,
    output logic                    o_last
);
    import tsfp_pkg::*;

    // Input register: one byte waits here until the queue can take two results.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       room;
    logic       advance;

    t_emit   emit;
    t_emit   emit_q;
    t_result head;

    // The parser runs only on an advancing item; otherwise it holds state.
    assign advance    = r_in_valid && room;
    // Ready does not wait on the result side directly: the queue keeps two slots
    // spare, so a fresh byte enters whenever the held one moves on.
    assign o_rx_ready = !r_in_valid || room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Line state, header match, number conversion and result building.
    tsfp_parser #(
        .LINE_STORE_BYTES (LINE_STORE_BYTES),
        .PAYLOAD_MAX      (PAYLOAD_MAX)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_byte  (r_in_byte),
        .o_emit  (emit)
    );

    // Nothing is pushed unless the item actually advances.
    always_comb begin
        emit_q = emit;
        if (!advance) emit_q.cnt = 2'd0;
    end

    // Result register stage: small in-order queue, head drives the ports.
    tsfp_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit_q),
        .i_pop   (i_res_ready),
        .o_head  (head),
        .o_valid (o_res_valid),
        .o_room  (room)
    );

    assign o_kind        = head.kind;
    assign o_msg_type    = head.msg_type;
    assign o_field_index = head.field_index;
    assign o_value       = head.value;
    assign o_last        = head.last;

endmodule

`default_nettype wire

/* hw/rtl/tsfp_parser.sv */
`default_nettype none

module tsfp_parser #(
    parameter int unsigned LINE_STORE_BYTES = 256,
    parameter int unsigned PAYLOAD_MAX      = 31
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire logic [7:0]       i_byte,
    output tsfp_pkg::t_emit       o_emit
);
    import tsfp_pkg::*;

    localparam int unsigned LW = $clog2(LINE_STORE_BYTES);
    localparam int unsigned PW = $clog2(PAYLOAD_MAX + 1);
    localparam logic [LW-1:0] LEN_CAP = LW'(LINE_STORE_BYTES - 1);
    localparam logic [PW-1:0] PAY_CAP = PW'(PAYLOAD_MAX);

    logic [LW-1:0] r_line_len, n_line_len;
    logic [3:0]    r_cand,     n_cand;
    logic          r_pfc,      n_pfc;
    logic          r_psc,      n_psc;
    logic [3:0]    r_field,    n_field;
    t_phase        r_phase,    n_phase;
    logic          r_neg,      n_neg;
    logic [31:0]   r_acc,      n_acc;
    logic [PW-1:0] r_pay_cnt,  n_pay_cnt;
    logic          r_text_end, n_text_end;

    logic [1:0]  known;
    logic [31:0] typed;
    logic [31:0] pay32;
    logic        is_eol, is_comma, is_digit, is_space;
    logic [3:0]  digit;
    logic        do_feed, do_start;
    t_result     fld_res, end_res;
    t_emit       emit;

    function automatic logic [1:0] known_type(input logic [3:0] c);
        logic [1:0] t;
        priority if (c[0]) t = MSG_GPS;
        else if (c[1])     t = MSG_IMU;
        else if (c[2])     t = MSG_VIS;
        else if (c[3])     t = MSG_CMD;
        else               t = MSG_GPS;
        return t;
    endfunction

    // Signed value wrapped to 32 bits, then cut to the field's type
    function automatic logic [31:0] typed_val(input logic [1:0] t, input logic [3:0] idx,
                                              input logic neg, input logic [31:0] acc);
        logic [31:0] v;
        logic [31:0] r;
        v = neg ? (32'd0 - acc) : acc;
        unique case (t)
            MSG_GPS: begin
                if (idx <= 4'd2)      r = v;
                else if (idx <= 4'd4) r = {16'd0, v[15:0]};
                else                  r = {24'd0, v[7:0]};
            end
            MSG_IMU: r = {{16{v[15]}}, v[15:0]};
            MSG_VIS: begin
                if (idx <= 4'd3) r = {16'd0, v[15:0]};
                else             r = {24'd0, v[7:0]};
            end
            MSG_CMD: r = {24'd0, v[7:0]};
        endcase
        return r;
    endfunction

    always_comb begin
        known    = known_type(r_cand);
        typed    = typed_val(known, r_field, r_neg, r_acc);
        pay32    = 32'(r_pay_cnt);
        is_eol   = (i_byte == CH_LF) || (i_byte == CH_CR);
        is_comma = (i_byte == CH_COMMA);
        is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
        is_space = (i_byte == CH_SPACE) || (i_byte == CH_TAB) ||
                   (i_byte == CH_VT) || (i_byte == CH_FF);
        digit    = 4'(i_byte - CH_ZERO);

        fld_res.kind        = KIND_FIELD;
        fld_res.msg_type    = known;
        fld_res.field_index = (known == MSG_CMD) ? 5'd0 : {1'b0, r_field};
        fld_res.value       = typed;
        fld_res.last        = 1'b0;

        end_res.kind        = KIND_END;
        end_res.msg_type    = known;
        end_res.field_index = 5'd0;
        end_res.value       = (known == MSG_CMD) ? pay32 : 32'd0;
        end_res.last        = 1'b1;
    end

    always_comb begin
        n_line_len = r_line_len;
        n_cand     = r_cand;
        n_pfc      = r_pfc;
        n_psc      = r_psc;
        n_field    = r_field;
        n_phase    = r_phase;
        n_neg      = r_neg;
        n_acc      = r_acc;
        n_pay_cnt  = r_pay_cnt;
        n_text_end = r_text_end;
        emit       = '0;
        do_feed    = 1'b0;
        do_start   = 1'b0;

        if (i_fire) begin
            if (is_eol) begin
                if (r_line_len != '0) begin
                    if ((r_line_len >= LW'(HDR_LEN)) && (r_cand != 4'd0)) begin
                        // field still open at end of line closes here
                        if ((known == MSG_CMD) ? (r_pfc && !r_psc)
                                               : (r_pfc && (r_field < field_limit(known)))) begin
                            emit.cnt  = 2'd2;
                            emit.res0 = fld_res;
                            emit.res1 = end_res;
                        end else begin
                            emit.cnt  = 2'd1;
                            emit.res0 = end_res;
                        end
                    end
                    n_line_len = '0;
                    n_cand     = 4'hF;
                    n_pfc      = 1'b0;
                    n_psc      = 1'b0;
                    n_field    = 4'd0;
                    n_pay_cnt  = '0;
                    n_text_end = 1'b0;
                    do_start   = 1'b1;
                end
            end else if (r_line_len < LEN_CAP) begin
                n_line_len = r_line_len + LW'(1);
                if (r_text_end) begin
                    // text already ended by a zero byte
                end else if (i_byte == CH_NUL) begin
                    n_text_end = 1'b1;
                    if (r_line_len < LW'(HDR_LEN)) n_cand = 4'd0;
                end else if (r_line_len < LW'(HDR_LEN)) begin
                    for (int t = 0; t < 4; t++) begin
                        if (hdr_char(2'(t), r_line_len[1:0]) != i_byte) n_cand[t] = 1'b0;
                    end
                end else if (r_cand != 4'd0) begin
                    if (!r_pfc) begin
                        if (is_comma) begin
                            n_pfc    = 1'b1;
                            n_field  = 4'd0;
                            do_start = 1'b1;
                        end
                    end else if (known == MSG_CMD) begin
                        if (!r_psc) begin
                            if (is_comma) begin
                                emit.cnt       = 2'd1;
                                emit.res0      = fld_res;
                                emit.res0.last = 1'b1;
                                n_psc          = 1'b1;
                                n_pay_cnt      = '0;
                            end else begin
                                do_feed = 1'b1;
                            end
                        end else if (r_pay_cnt < PAY_CAP) begin
                            emit.cnt              = 2'd1;
                            emit.res0.kind        = KIND_PAYLOAD;
                            emit.res0.msg_type    = known;
                            emit.res0.field_index = pay32[4:0];
                            emit.res0.value       = {24'd0, i_byte};
                            emit.res0.last        = 1'b1;
                            n_pay_cnt             = r_pay_cnt + PW'(1);
                        end
                    end else if (r_field < field_limit(known)) begin
                        if (is_comma) begin
                            emit.cnt       = 2'd1;
                            emit.res0      = fld_res;
                            emit.res0.last = 1'b1;
                            n_field        = r_field + 4'd1;
                            do_start       = 1'b1;
                        end else begin
                            do_feed = 1'b1;
                        end
                    end
                end
            end
        end

        if (do_start) begin
            n_phase = PH_SPACE;
            n_neg   = 1'b0;
            n_acc   = 32'd0;
        end else if (do_feed) begin
            unique case (r_phase)
                PH_SPACE: begin
                    if (is_space) begin
                        // skip leading blanks
                    end else if (i_byte == CH_PLUS) begin
                        n_phase = PH_DIGITS;
                    end else if (i_byte == CH_MINUS) begin
                        n_neg   = 1'b1;
                        n_phase = PH_DIGITS;
                    end else if (is_digit) begin
                        n_acc   = 32'(digit);
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DIGITS: begin
                    if (is_digit) n_acc = (r_acc << 3) + (r_acc << 1) + 32'(digit);
                    else          n_phase = PH_DONE;
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign o_emit = emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len <= '0;
            r_cand     <= 4'hF;
            r_pfc      <= 1'b0;
            r_psc      <= 1'b0;
            r_field    <= 4'd0;
            r_phase    <= PH_SPACE;
            r_neg      <= 1'b0;
            r_acc      <= 32'd0;
            r_pay_cnt  <= '0;
            r_text_end <= 1'b0;
        end else begin
            r_line_len <= n_line_len;
            r_cand     <= n_cand;
            r_pfc      <= n_pfc;
            r_psc      <= n_psc;
            r_field    <= n_field;
            r_phase    <= n_phase;
            r_neg      <= n_neg;
            r_acc      <= n_acc;
            r_pay_cnt  <= n_pay_cnt;
            r_text_end <= n_text_end;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/tsfp_result_queue.sv */
`default_nettype none

module tsfp_result_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  tsfp_pkg::t_emit       i_emit,
    input  wire logic             i_pop,
    output tsfp_pkg::t_result     o_head,
    output logic                  o_valid,
    output logic                  o_room
);
    import tsfp_pkg::*;

    t_result           r_q [QUEUE_DEPTH];
    t_result           n_q [QUEUE_DEPTH];
    logic [QCNT_W-1:0] r_cnt, n_cnt, cnt_ap;
    logic              pop;

    // Shift queue: head is entry 0, new items land right after the survivors
    always_comb begin
        pop    = i_pop && (r_cnt != '0);
        cnt_ap = r_cnt - QCNT_W'(pop);
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (pop && (i < QUEUE_DEPTH - 1)) n_q[i] = r_q[(i + 1) % QUEUE_DEPTH];
            else                              n_q[i] = r_q[i];
            if ((i_emit.cnt != 2'd0) && (QCNT_W'(i) == cnt_ap)) n_q[i] = i_emit.res0;
            if ((i_emit.cnt == 2'd2) && (QCNT_W'(i) == cnt_ap + QCNT_W'(1)))
                n_q[i] = i_emit.res1;
        end
        n_cnt = cnt_ap + QCNT_W'(i_emit.cnt);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) r_q[i] <= n_q[i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_head  = r_q[0];
    assign o_valid = (r_cnt != '0);
    assign o_room  = (r_cnt <= QCNT_W'(QUEUE_DEPTH - 2));

endmodule

`default_nettype wire
